[rtl/core/sha1md_pkg.sv]
// Shared types, constants and command/status structs for the SHA-1 digest block
`timescale 1ns / 1ps

package sha1md_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] FILL_POS = 6'd63;
    localparam logic [6:0] LAST_ROUND = 7'd79;

    localparam logic [1:0] MODE_DATA  = 2'd0;
    localparam logic [1:0] MODE_FINAL = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;

    localparam logic [1:0] SEL_DATA = 2'd0;
    localparam logic [1:0] SEL_PAD  = 2'd1;
    localparam logic [1:0] SEL_ZERO = 2'd2;
    localparam logic [1:0] SEL_LEN  = 2'd3;

    localparam logic [2:0] LAST_WORD_IDX = 3'd4;

    typedef struct packed {
        logic       put;
        logic [1:0] byte_sel;
        logic       count;
        logic [2:0] len_idx;
        logic       round;
        logic       add;
        logic       init;
        logic [2:0] word_idx;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
        logic at_len_pos;
        logic round_last;
    } t_sts;

endpackage

[rtl/core/sha1md_in_if.sv]
// Input channel: message bytes with mode
`timescale 1ns / 1ps

interface sha1md_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

[rtl/core/sha1md_out_if.sv]
// Output channel: digest words
`timescale 1ns / 1ps

interface sha1md_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last_word,
                    output ready);
endinterface

[rtl/core/sha1_message_digest.sv]
// Top level of the SHA-1 message digest block
//
//  channel  | dir | beat payload                          | handshake
//  i_in     | in  | mode, data_byte                       | valid/ready
//  o_out    | out | digest_word, word_index, last_word    | valid/ready
//
// Data bytes are taken while idle; a byte that fills a block starts its compression
// (80 rounds in the single round unit, one hash update), during which input is held off.
// Message end: padding and length bytes go in one at a time, with a step on reaching the
// length field and one for an end beat without a byte; each block, one or two, is compressed.
// Digest: five beats, one per cycle while o_out.ready is high; stalls hold the word.
// Input is taken only when no block or digest is in progress.
// Reset restores the initial hash words and clears all counters at once.
`timescale 1ns / 1ps

module sha1_message_digest
    import sha1md_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    sha1md_in_if.sink    i_in,
    sha1md_out_if.source o_out
);

    t_cmd cmd;
    t_sts sts;

    sha1md_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_mode    (i_in.mode),
        .o_in_ready   (i_in.ready),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_word_index (o_out.word_index),
        .o_last_word  (o_out.last_word),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    sha1md_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_in.data_byte),
        .o_sts         (sts),
        .o_digest_word (o_out.digest_word)
    );

endmodule

[rtl/core/sha1md_datapath.sv]
// Datapath: block shift register, byte counters, round unit and hash words
`timescale 1ns / 1ps

module sha1md_datapath
    import sha1md_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_data_byte,
    output t_sts        o_sts,
    output logic [31:0] o_digest_word
);

    logic [511:0]      r_blk;
    logic [4:0][31:0]  r_hash;
    logic [4:0][31:0]  r_var;
    logic [5:0]        r_bytes;
    logic [60:0]       r_msg_bytes;
    logic [6:0]        r_round;

    logic [63:0] bit_len;
    logic [7:0]  put_val;
    logic [31:0] cur;
    logic [31:0] sched;
    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] tmp;
    logic [31:0] a, b, c, d, e;

    assign bit_len = {r_msg_bytes, 3'b000};
    assign a = r_var[0];
    assign b = r_var[1];
    assign c = r_var[2];
    assign d = r_var[3];
    assign e = r_var[4];

    always_comb begin
        case (i_cmd.byte_sel)
            SEL_DATA: put_val = i_data_byte;
            SEL_PAD:  put_val = PAD_BYTE;
            SEL_ZERO: put_val = 8'h00;
            SEL_LEN:  put_val = bit_len[{i_cmd.len_idx, 3'b000} +: 8];
            default:  put_val = 8'h00;
        endcase
    end

    assign sched = r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ r_blk[511:480];
    assign cur   = (r_round < 7'd16) ? r_blk[511:480] : {sched[30:0], sched[31]};

    always_comb begin
        if (r_round < 7'd20) begin
            f = (b & c) | (~b & d);
            k = K0;
        end else if (r_round < 7'd40) begin
            f = b ^ c ^ d;
            k = K1;
        end else if (r_round < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K2;
        end else begin
            f = b ^ c ^ d;
            k = K3;
        end
    end

    assign tmp = {a[26:0], a[31:27]} + f + e + k + cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= {IV4, IV3, IV2, IV1, IV0};
            r_var       <= '0;
            r_bytes     <= '0;
            r_msg_bytes <= '0;
            r_round     <= '0;
        end else begin
            if (i_cmd.put) begin
                r_blk   <= {r_blk[503:0], put_val};
                r_bytes <= r_bytes + 6'd1;
                if (r_bytes == FILL_POS) begin
                    r_var   <= r_hash;
                    r_round <= '0;
                end
            end
            if (i_cmd.count) begin
                r_msg_bytes <= r_msg_bytes + 61'd1;
            end
            if (i_cmd.round) begin
                r_blk   <= {r_blk[479:0], cur};
                r_var   <= {d, c, {b[1:0], b[31:2]}, a, tmp};
                r_round <= (r_round == LAST_ROUND) ? 7'd0 : r_round + 7'd1;
            end
            if (i_cmd.add) begin
                r_hash[0] <= r_hash[0] + r_var[0];
                r_hash[1] <= r_hash[1] + r_var[1];
                r_hash[2] <= r_hash[2] + r_var[2];
                r_hash[3] <= r_hash[3] + r_var[3];
                r_hash[4] <= r_hash[4] + r_var[4];
            end
            if (i_cmd.init) begin
                r_hash      <= {IV4, IV3, IV2, IV1, IV0};
                r_bytes     <= '0;
                r_msg_bytes <= '0;
                r_round     <= '0;
            end
        end
    end

    assign o_sts.fill_last  = (r_bytes == FILL_POS);
    assign o_sts.at_len_pos = (r_bytes == LEN_POS);
    assign o_sts.round_last = (r_round == LAST_ROUND);

    always_comb begin
        case (i_cmd.word_idx)
            3'd0:    o_digest_word = r_hash[0];
            3'd1:    o_digest_word = r_hash[1];
            3'd2:    o_digest_word = r_hash[2];
            3'd3:    o_digest_word = r_hash[3];
            3'd4:    o_digest_word = r_hash[4];
            default: o_digest_word = r_hash[0];
        endcase
    end

endmodule

[rtl/core/sha1md_ctrl.sv]
// Controller: byte intake, padding sequence, round sequencing and digest output
`timescale 1ns / 1ps

module sha1md_ctrl
    import sha1md_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_mode,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_word_index,
    output logic       o_last_word,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ZERO  = 3'd2;
    localparam logic [2:0] S_LEN   = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_ADD   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_ret, n_ret;
    logic [2:0] r_len_idx, n_len_idx;
    logic [2:0] r_word_idx, n_word_idx;

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_len_idx  = r_len_idx;
        n_word_idx = r_word_idx;
        o_cmd          = '0;
        o_cmd.len_idx  = r_len_idx;
        o_cmd.word_idx = r_word_idx;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_mode)
                        MODE_DATA: begin
                            o_cmd.put      = 1'b1;
                            o_cmd.byte_sel = SEL_DATA;
                            o_cmd.count    = 1'b1;
                            if (i_sts.fill_last) begin
                                n_state = S_ROUND;
                                n_ret   = S_IDLE;
                            end
                        end
                        MODE_FINAL: begin
                            o_cmd.put      = 1'b1;
                            o_cmd.byte_sel = SEL_DATA;
                            o_cmd.count    = 1'b1;
                            if (i_sts.fill_last) begin
                                n_state = S_ROUND;
                                n_ret   = S_PAD;
                            end else begin
                                n_state = S_PAD;
                            end
                        end
                        MODE_END: begin
                            n_state = S_PAD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PAD: begin
                o_cmd.put      = 1'b1;
                o_cmd.byte_sel = SEL_PAD;
                if (i_sts.fill_last) begin
                    n_state = S_ROUND;
                    n_ret   = S_ZERO;
                end else begin
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                if (i_sts.at_len_pos) begin
                    n_state   = S_LEN;
                    n_len_idx = 3'd7;
                end else begin
                    o_cmd.put      = 1'b1;
                    o_cmd.byte_sel = SEL_ZERO;
                    if (i_sts.fill_last) begin
                        n_state = S_ROUND;
                        n_ret   = S_ZERO;
                    end
                end
            end
            S_LEN: begin
                o_cmd.put      = 1'b1;
                o_cmd.byte_sel = SEL_LEN;
                n_len_idx      = r_len_idx - 3'd1;
                if (r_len_idx == 3'd0) begin
                    n_state    = S_ROUND;
                    n_ret      = S_OUT;
                    n_word_idx = 3'd0;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_sts.round_last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = r_ret;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_word_idx == LAST_WORD_IDX) begin
                        o_cmd.init = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_word_idx = r_word_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_len_idx  <= '0;
            r_word_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_len_idx  <= n_len_idx;
            r_word_idx <= n_word_idx;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_word_index = r_word_idx;
    assign o_last_word  = (r_word_idx == LAST_WORD_IDX);

endmodule

[sim/sha1_message_digest_test.sv]
// Self-checking testbench for the SHA-1 message digest block: byte stream in, digest words out
`timescale 1ns / 1ps

import sha1md_pkg::*;

localparam logic [1:0] MODE_UNUSED = 2'd3;

typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
} t_digest_beat;

class digest_scoreboard;
    logic [31:0]  chain[5];
    logic [31:0]  block_buf[16];
    logic [5:0]   fill;
    logic [60:0]  msg_len;
    t_digest_beat due[$];
    int           errors;

    function new();
        errors = 0;
        restart();
    endfunction

    function void restart();
        chain[0] = IV0;
        chain[1] = IV1;
        chain[2] = IV2;
        chain[3] = IV3;
        chain[4] = IV4;
        fill     = '0;
        msg_len  = '0;
    endfunction

    function void compress_block();
        logic [31:0] w[16];
        logic [31:0] a, b, c, d, e, f, k, cur, tmp;
        w = block_buf;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                cur = w[t];
            end else begin
                cur = w[(t - 3) % 16] ^ w[(t - 8) % 16] ^ w[(t - 14) % 16] ^ w[t % 16];
                cur = {cur[30:0], cur[31]};
                w[t % 16] = cur;
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end else begin
                f = b ^ c ^ d;
                k = K3;
            end
            tmp = {a[26:0], a[31:27]} + f + e + k + cur;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    function void absorb_byte(logic [7:0] value);
        block_buf[fill[5:2]][(3 - fill[1:0]) * 8 +: 8] = value;
        fill++;
        if (fill == 6'd0) begin
            compress_block();
        end
    endfunction

    function void close_message();
        logic [63:0]  bit_len;
        t_digest_beat entry;
        bit_len = {msg_len, 3'b000};
        absorb_byte(PAD_BYTE);
        while (fill != LEN_POS) begin
            absorb_byte(8'h00);
        end
        for (int i = 7; i >= 0; i--) begin
            absorb_byte(bit_len[8 * i +: 8]);
        end
        for (int i = 0; i < 5; i++) begin
            entry.word  = chain[i];
            entry.index = i[2:0];
            entry.last  = (i[2:0] == LAST_WORD_IDX);
            due = {due, entry};
        end
        restart();
    endfunction

    function void note_beat(logic [1:0] mode, logic [7:0] value);
        case (mode)
            MODE_DATA: begin
                absorb_byte(value);
                msg_len++;
            end
            MODE_FINAL: begin
                absorb_byte(value);
                msg_len++;
                close_message();
            end
            MODE_END: begin
                close_message();
            end
            default: begin
            end
        endcase
    endfunction

    function void check_word(logic [31:0] word, logic [2:0] index, logic last);
        t_digest_beat exp_beat;
        if (due.size() == 0) begin
            $display("%0t unexpected digest beat: word %h index %0d last %0b",
                     $time, word, index, last);
            errors++;
            return;
        end
        exp_beat = due.pop_front();
        if (word !== exp_beat.word) begin
            $display("%0t digest_word mismatch: expected %h actual %h",
                     $time, exp_beat.word, word);
            errors++;
        end
        if (index !== exp_beat.index) begin
            $display("%0t word_index mismatch: expected %0d actual %0d",
                     $time, exp_beat.index, index);
            errors++;
        end
        if (last !== exp_beat.last) begin
            $display("%0t last_word mismatch: expected %0b actual %0b",
                     $time, exp_beat.last, last);
            errors++;
        end
    endfunction
endclass

module sha1_message_digest_test;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int ITEM_TARGET    = 210;
    localparam int WORD_TARGET    = 40;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;

    logic i_clk;
    logic i_rst_n;

    sha1md_in_if  in_ch();
    sha1md_out_if out_ch();

    digest_scoreboard board = new();

    int items_sent;
    int words_due;
    int idle_cycles;
    bit long_hold_req;

    sha1_message_digest u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_beat(logic [1:0] mode, logic [7:0] value);
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= mode;
        in_ch.data_byte <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (mode != MODE_UNUSED) items_sent++;
    endtask

    task automatic pause(int cycles);
        if (cycles > 0) begin
            in_ch.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic send_message(int len, bit end_item, bit gapless);
        logic [1:0] mode;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_beat(MODE_UNUSED, 8'($urandom_range(0, 255)));
                pause(gapless ? 0 : gap_len());
            end
            mode = (i == len - 1 && !end_item) ? MODE_FINAL : MODE_DATA;
            send_beat(mode, 8'($urandom_range(0, 255)));
            pause(gapless ? 0 : gap_len());
        end
        if (len == 0 || end_item) begin
            send_beat(MODE_END, 8'($urandom_range(0, 255)));
            pause(gapless ? 0 : gap_len());
        end
        words_due += 5;
    endtask

    // receiver: random ready, one long hold on request
    initial begin
        int hold;
        int run;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else begin
                hold = gap_len();
            end
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
            out_ch.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            board.note_beat(in_ch.mode, in_ch.data_byte);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            board.check_word(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int msg_no;
        int len;
        bit pressure;
        items_sent      = 0;
        words_due       = 0;
        long_hold_req   = 1'b0;
        idle_cycles     = 0;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.mode      <= MODE_DATA;
        in_ch.data_byte <= 8'h00;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, then "abc" closed by a final byte and by an end beat, then one-byte messages closed each way
        send_beat(MODE_END, 8'hFF);
        send_beat(MODE_DATA, 8'h61);
        send_beat(MODE_DATA, 8'h62);
        send_beat(MODE_FINAL, 8'h63);
        send_beat(MODE_DATA, 8'h61);
        send_beat(MODE_DATA, 8'h62);
        send_beat(MODE_DATA, 8'h63);
        send_beat(MODE_END, 8'h00);
        send_beat(MODE_FINAL, 8'hFF);
        send_beat(MODE_DATA, 8'h00);
        send_beat(MODE_END, 8'hA5);
        // unused mode alone and inside a message, then another empty message
        send_beat(MODE_UNUSED, 8'hFF);
        send_beat(MODE_DATA, 8'h5A);
        send_beat(MODE_UNUSED, 8'h00);
        send_beat(MODE_FINAL, 8'hA5);
        send_beat(MODE_END, 8'h00);
        words_due += 35;
        pause(3);

        msg_no = 0;
        while (items_sent < ITEM_TARGET || words_due < WORD_TARGET) begin
            pressure = (msg_no == 2);
            if (pressure) begin
                long_hold_req = 1'b1;
                len = 3;
            end else if ($urandom_range(0, 9) < 7) begin
                len = $urandom_range(0, 8);
            end else begin
                len = $urandom_range(52, 68);
            end
            send_message(len, (len == 0) || ($urandom_range(0, 1) == 1),
                         pressure || ($urandom_range(0, 3) == 0));
            msg_no++;
        end
        in_ch.valid <= 1'b0;
        @(posedge i_clk);

        while (board.due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sha1_message_digest.f]
rtl/core/sha1md_pkg.sv
rtl/core/sha1md_in_if.sv
rtl/core/sha1md_out_if.sv
rtl/core/sha1md_datapath.sv
rtl/core/sha1md_ctrl.sv
rtl/core/sha1_message_digest.sv
sim/sha1_message_digest_test.sv
